// ----- sv/nand_page_read_sequencer_macros.svh -----
// Assertion macros shared by the checker of the NAND page read sequencer.
`ifndef NAND_PAGE_READ_SEQUENCER_MACROS_SVH
`define NAND_PAGE_READ_SEQUENCER_MACROS_SVH

// Check a property only while out of reset.
`define NPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define NPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/nps_pkg.sv -----
// Shared types and constants of the NAND page read sequencer.
`default_nettype none

package nps_pkg;

    localparam int unsigned PAGE_BYTES = 2048;
    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [PAGE_SHIFT-1:0] PAGE_LAST = PAGE_SHIFT'(PAGE_BYTES - 1);
    localparam logic [31:0] PAGE_STEP = 32'(PAGE_BYTES);

    // Input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_READY = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_SEL   = 3'd0;
    localparam logic [2:0] KIND_DESEL = 3'd1;
    localparam logic [2:0] KIND_CMD   = 3'd2;
    localparam logic [2:0] KIND_ADDR  = 3'd3;
    localparam logic [2:0] KIND_WRITE = 3'd4;
    localparam logic [2:0] KIND_DONE  = 3'd5;

    // Flash command bytes
    localparam logic [7:0] NAND_READ_SETUP   = 8'h00;
    localparam logic [7:0] NAND_READ_CONFIRM = 8'h30;

    // Tail of a job after its head result
    localparam logic [1:0] TAIL_NONE  = 2'd0;
    localparam logic [1:0] TAIL_CLOSE = 2'd1;
    localparam logic [1:0] TAIL_OPEN  = 2'd2;

    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

    // One classified item: head is select or memory write, then a tail
    typedef struct packed {
        logic        head_write;
        logic [1:0]  tail;
        logic [7:0]  data;
        logic [31:0] mem_addr;
        logic [31:0] flash_addr;
    } job_t;

endpackage

`default_nettype wire

// ----- sv/nps_front.sv -----
// Front part: accepts items, tracks read state and classifies each item into a job.
`default_nettype none

module nps_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_command,
    input  wire logic [31:0]  s_start_address,
    input  wire logic [31:0]  s_dest_address,
    input  wire logic [31:0]  s_length,
    input  wire logic [7:0]   s_flash_byte,
    input  wire logic         q_full,
    output logic              q_push,
    output nps_pkg::job_t     q_job
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]                     phase_reg, phase_next;
    logic [31:0]                    flash_reg, flash_next;
    logic [31:0]                    write_reg, write_next;
    logic [31:0]                    left_reg, left_next;
    logic [nps_pkg::PAGE_SHIFT-1:0] count_reg, count_next;
    logic                           accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next = phase_reg;
        flash_next = flash_reg;
        write_next = write_reg;
        left_next  = left_reg;
        count_next = count_reg;
        q_push     = 1'b0;
        q_job      = '0;
        q_job.data = s_flash_byte;
        if (accept) begin
            case (s_command)
                nps_pkg::CMD_START: begin
                    if (phase_reg == PH_IDLE) begin
                        flash_next       = s_start_address;
                        write_next       = s_dest_address;
                        left_next        = s_length;
                        count_next       = '0;
                        q_push           = 1'b1;
                        q_job.flash_addr = s_start_address;
                        if (s_length == 32'd0) begin
                            q_job.tail = nps_pkg::TAIL_CLOSE;
                        end else begin
                            q_job.tail = nps_pkg::TAIL_OPEN;
                            phase_next = PH_WAIT;
                        end
                    end
                end
                nps_pkg::CMD_READY: begin
                    if (phase_reg == PH_WAIT) begin
                        phase_next = PH_DATA;
                    end
                end
                nps_pkg::CMD_DATA: begin
                    if (phase_reg == PH_DATA) begin
                        q_push           = 1'b1;
                        q_job.head_write = 1'b1;
                        q_job.mem_addr   = write_reg;
                        write_next       = write_reg + 32'd1;
                        left_next        = left_reg - 32'd1;
                        if (left_reg == 32'd1) begin
                            q_job.tail = nps_pkg::TAIL_CLOSE;
                            count_next = '0;
                            phase_next = PH_IDLE;
                        end else if (count_reg == nps_pkg::PAGE_LAST) begin
                            // page full: move to the next page, same column
                            flash_next       = flash_reg + nps_pkg::PAGE_STEP;
                            q_job.flash_addr = flash_reg + nps_pkg::PAGE_STEP;
                            q_job.tail       = nps_pkg::TAIL_OPEN;
                            count_next       = '0;
                            phase_next       = PH_WAIT;
                        end else begin
                            q_job.tail = nps_pkg::TAIL_NONE;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            flash_reg <= '0;
            write_reg <= '0;
            left_reg  <= '0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            flash_reg <= flash_next;
            write_reg <= write_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/nps_queue.sv -----
// Job queue between the front and back parts.
`default_nettype none

module nps_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire nps_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output nps_pkg::job_t      head_job
);

    localparam int unsigned CW = $clog2(nps_pkg::QUEUE_DEPTH + 1);

    nps_pkg::job_t                  mem_reg [nps_pkg::QUEUE_DEPTH];
    logic [nps_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [nps_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic                           do_push, do_pop;

    assign full       = (count_reg == CW'(nps_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/nps_back.sv -----
// Back part: expands each job into registered bus results, one per cycle unless stalled.
`default_nettype none

module nps_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire nps_pkg::job_t q_job,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_cycle_kind,
    output logic [7:0]         m_bus_byte,
    output logic [31:0]        m_memory_address,
    output logic               m_last
);

    logic [2:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [31:0] addr_reg, addr_next;
    logic        last_reg, last_next;
    logic        load;
    logic [31:0] column;
    logic [31:0] page;
    logic [2:0]  kind_c;
    logic [7:0]  byte_c;
    logic [31:0] addr_c;
    logic        last_c;

    assign load   = q_valid && (!valid_reg || m_ready);
    assign column = q_job.flash_addr & (nps_pkg::PAGE_STEP - 32'd1);
    assign page   = q_job.flash_addr >> nps_pkg::PAGE_SHIFT;

    always_comb begin
        kind_c = nps_pkg::KIND_SEL;
        byte_c = '0;
        addr_c = '0;
        if (step_reg == 3'd0) begin
            if (q_job.head_write) begin
                kind_c = nps_pkg::KIND_WRITE;
                byte_c = q_job.data;
                addr_c = q_job.mem_addr;
            end
        end else if (q_job.tail == nps_pkg::TAIL_CLOSE) begin
            kind_c = (step_reg == 3'd1) ? nps_pkg::KIND_DESEL : nps_pkg::KIND_DONE;
        end else begin
            kind_c = nps_pkg::KIND_ADDR;
            case (step_reg)
                3'd1: begin
                    kind_c = nps_pkg::KIND_CMD;
                    byte_c = nps_pkg::NAND_READ_SETUP;
                end
                3'd2: byte_c = column[7:0];
                3'd3: byte_c = column[15:8];
                3'd4: byte_c = page[7:0];
                3'd5: byte_c = page[15:8];
                3'd6: byte_c = page[23:16];
                default: begin
                    kind_c = nps_pkg::KIND_CMD;
                    byte_c = nps_pkg::NAND_READ_CONFIRM;
                end
            endcase
        end
        case (q_job.tail)
            nps_pkg::TAIL_CLOSE: last_c = (step_reg == 3'd2);
            nps_pkg::TAIL_OPEN:  last_c = (step_reg == 3'd7);
            default:             last_c = (step_reg == 3'd0);
        endcase
    end

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg && !m_ready;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            kind_next  = kind_c;
            byte_next  = byte_c;
            addr_next  = addr_c;
            last_next  = last_c;
            // drop the job once its final result is loaded
            if (last_c) begin
                step_next = '0;
                q_pop     = 1'b1;
            end else begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        addr_reg <= addr_next;
        last_reg <= last_next;
    end

    assign m_valid          = valid_reg;
    assign m_cycle_kind     = kind_reg;
    assign m_bus_byte       = byte_reg;
    assign m_memory_address = addr_reg;
    assign m_last           = last_reg;

endmodule

`default_nettype wire

// ----- sv/nand_page_read_sequencer.sv -----
// Top level of the NAND large-page read sequencer.
//
//  channel | ports                                              | direction
//  s_      | command, start_address, dest_address, length, byte | in  (valid/ready)
//  m_      | cycle_kind, bus_byte, memory_address, last         | out (valid/ready)
//
// Every accepted item is classified combinationally as it is accepted; items that cause
// results are queued (4 jobs deep). The back part emits results per job: 1 for a data
// byte, 3 for a zero length start or a final byte, 8 for a start that opens a
// page or at a page boundary; the output register sustains one result per cycle
// while m_ready does not stall it.
// A full queue drops s_ready; a stalled m_ready holds the output register.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none

module nand_page_read_sequencer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_command,
    input  wire logic [31:0]  s_start_address,
    input  wire logic [31:0]  s_dest_address,
    input  wire logic [31:0]  s_length,
    input  wire logic [7:0]   s_flash_byte,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_cycle_kind,
    output logic [7:0]        m_bus_byte,
    output logic [31:0]       m_memory_address,
    output logic              m_last
);

    nps_pkg::job_t push_job;
    nps_pkg::job_t head_job;
    logic          push;
    logic          full;
    logic          pop;
    logic          head_valid;

    nps_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_start_address (s_start_address),
        .s_dest_address  (s_dest_address),
        .s_length        (s_length),
        .s_flash_byte    (s_flash_byte),
        .q_full          (full),
        .q_push          (push),
        .q_job           (push_job)
    );

    nps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    nps_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (head_valid),
        .q_job            (head_job),
        .q_pop            (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cycle_kind     (m_cycle_kind),
        .m_bus_byte       (m_bus_byte),
        .m_memory_address (m_memory_address),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

// ----- sv/nps_checker.sv -----
// Port-level checker of the NAND page read sequencer and its bind.
`default_nettype none

`include "nand_page_read_sequencer_macros.svh"

module nps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_cycle_kind,
    input wire logic [7:0]  m_bus_byte,
    input wire logic [31:0] m_memory_address,
    input wire logic        m_last
);

    property p_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_cycle_kind) && $stable(m_bus_byte) &&
            $stable(m_memory_address) && $stable(m_last);
    endproperty

    property p_done_last;
        m_valid && m_cycle_kind == nps_pkg::KIND_DONE |-> m_last;
    endproperty

    property p_addr_zero;
        m_valid && m_cycle_kind != nps_pkg::KIND_WRITE |-> m_memory_address == 32'd0;
    endproperty

    property p_select_opens;
        m_valid && m_cycle_kind == nps_pkg::KIND_SEL |-> !m_last;
    endproperty

    `NPS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")
    `NPS_ASSERT(a_hold, p_hold, "stalled result changed")
    `NPS_ASSERT(a_done_last, p_done_last, "done not last")
    `NPS_ASSERT(a_addr_zero, p_addr_zero, "address on non-write")
    `NPS_ASSERT(a_select_opens, p_select_opens, "select closes an item")

endmodule

bind nand_page_read_sequencer nps_checker u_nps_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the NAND large-page read sequencer, with a bus-cycle predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {RD_IDLE, RD_WAIT, RD_DATA} rd_phase_e;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] flash_start;
        logic [31:0] dest;
        logic [31:0] len;
        logic [7:0]  fbyte;
    } read_item_t;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  bus_byte;
        logic [31:0] mem_addr;
        logic        last;
    } bus_cycle_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = nps_pkg::CMD_START;
    logic [31:0] s_start_address = '0;
    logic [31:0] s_dest_address = '0;
    logic [31:0] s_length = '0;
    logic [7:0]  s_flash_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_cycle_kind;
    logic [7:0]  m_bus_byte;
    logic [31:0] m_memory_address;
    logic        m_last;

    nand_page_read_sequencer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_start_address  (s_start_address),
        .s_dest_address   (s_dest_address),
        .s_length         (s_length),
        .s_flash_byte     (s_flash_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cycle_kind     (m_cycle_kind),
        .m_bus_byte       (m_bus_byte),
        .m_memory_address (m_memory_address),
        .m_last           (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    read_item_t pending_items[$];
    bus_cycle_t expected_cycles[$];

    // Predictor state
    rd_phase_e                    rd_phase = RD_IDLE;
    logic [31:0]                  flash_addr = '0;
    logic [31:0]                  write_addr = '0;
    logic [31:0]                  bytes_left = '0;
    logic [nps_pkg::PAGE_SHIFT:0] page_count = '0;

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  read_items_queued = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  item_taken = 1'b0;
    bit  result_taken = 1'b0;

    function automatic void push_cycle(logic [2:0] kind, logic [7:0] b, logic [31:0] maddr,
                                       logic last);
        bus_cycle_t c;
        c.kind = kind;
        c.bus_byte = b;
        c.mem_addr = maddr;
        c.last = last;
        expected_cycles.push_back(c);
    endfunction

    function automatic void open_page();
        logic [31:0] col;
        logic [31:0] pg;
        col = flash_addr % nps_pkg::PAGE_STEP;
        pg = flash_addr / nps_pkg::PAGE_STEP;
        push_cycle(nps_pkg::KIND_CMD, nps_pkg::NAND_READ_SETUP, '0, 1'b0);
        push_cycle(nps_pkg::KIND_ADDR, col[7:0], '0, 1'b0);
        push_cycle(nps_pkg::KIND_ADDR, col[15:8], '0, 1'b0);
        push_cycle(nps_pkg::KIND_ADDR, pg[7:0], '0, 1'b0);
        push_cycle(nps_pkg::KIND_ADDR, pg[15:8], '0, 1'b0);
        push_cycle(nps_pkg::KIND_ADDR, pg[23:16], '0, 1'b0);
        push_cycle(nps_pkg::KIND_CMD, nps_pkg::NAND_READ_CONFIRM, '0, 1'b1);
        page_count = '0;
        rd_phase = RD_WAIT;
    endfunction

    function automatic void close_read();
        push_cycle(nps_pkg::KIND_DESEL, '0, '0, 1'b0);
        push_cycle(nps_pkg::KIND_DONE, '0, '0, 1'b1);
        page_count = '0;
        rd_phase = RD_IDLE;
    endfunction

    function automatic void predict_bus_cycles(read_item_t it);
        bit ends;
        bit turns;
        if (it.cmd == nps_pkg::CMD_START && rd_phase == RD_IDLE) begin
            flash_addr = it.flash_start;
            write_addr = it.dest;
            bytes_left = it.len;
            page_count = '0;
            push_cycle(nps_pkg::KIND_SEL, '0, '0, 1'b0);
            if (it.len == 0)
                close_read();
            else
                open_page();
        end else if (it.cmd == nps_pkg::CMD_READY && rd_phase == RD_WAIT) begin
            rd_phase = RD_DATA;
        end else if (it.cmd == nps_pkg::CMD_DATA && rd_phase == RD_DATA) begin
            bytes_left = bytes_left - 1;
            page_count = page_count + 1'b1;
            ends = (bytes_left == 0);
            turns = !ends && (32'(page_count) >= nps_pkg::PAGE_BYTES);
            push_cycle(nps_pkg::KIND_WRITE, it.fbyte, write_addr, !(ends || turns));
            write_addr = write_addr + 1;
            if (ends) begin
                close_read();
            end else if (turns) begin
                flash_addr = flash_addr + nps_pkg::PAGE_STEP;
                open_page();
            end
        end
    endfunction

    function automatic void add_item(logic [1:0] cmd, logic [31:0] fs, logic [31:0] da,
                                     logic [31:0] len, logic [7:0] fb);
        read_item_t it;
        it.cmd = cmd;
        it.flash_start = fs;
        it.dest = da;
        it.len = len;
        it.fbyte = fb;
        pending_items.push_back(it);
    endfunction

    // Queue an item that the sequencer should drop in the given phase, all fields random.
    function automatic void maybe_noise(rd_phase_e where, int pct);
        logic [1:0] cmd;
        int pick;
        if ($urandom_range(0, 99) < pct) begin
            pick = $urandom_range(0, 2);
            case (where)
                RD_IDLE: cmd = (pick == 0) ? nps_pkg::CMD_READY :
                               (pick == 1) ? nps_pkg::CMD_DATA : CMD_UNUSED;
                RD_WAIT: cmd = (pick == 0) ? nps_pkg::CMD_START :
                               (pick == 1) ? nps_pkg::CMD_DATA : CMD_UNUSED;
                default: cmd = (pick == 0) ? nps_pkg::CMD_START :
                               (pick == 1) ? nps_pkg::CMD_READY : CMD_UNUSED;
            endcase
            add_item(cmd, $urandom, $urandom, $urandom, 8'($urandom));
        end
    endfunction

    // Queue one read; cut drops that many trailing data items to break the sequence.
    function automatic void queue_read(logic [31:0] fs, logic [31:0] da, logic [31:0] len,
                                       int pct, int cut);
        int unsigned to_send;
        int unsigned sent;
        to_send = (len > cut) ? len - cut : 0;
        maybe_noise(RD_IDLE, pct);
        add_item(nps_pkg::CMD_START, fs, da, len, 8'($urandom));
        read_items_queued++;
        for (sent = 0; sent < to_send; sent++) begin
            if (sent % nps_pkg::PAGE_BYTES == 0) begin
                maybe_noise(RD_WAIT, pct);
                add_item(nps_pkg::CMD_READY, $urandom, $urandom, $urandom, 8'($urandom));
                read_items_queued++;
            end
            maybe_noise(RD_DATA, pct);
            add_item(nps_pkg::CMD_DATA, $urandom, $urandom, $urandom, 8'($urandom));
            read_items_queued++;
        end
    endfunction

    // Predict on accepted items, then check accepted results against the oldest expectation.
    always @(posedge aclk) begin : sample
        read_item_t in_it;
        bus_cycle_t want;
        if (aresetn) begin
            item_taken = s_valid && s_ready;
            result_taken = m_valid && m_ready;
            if (item_taken) begin
                in_it.cmd = s_command;
                in_it.flash_start = s_start_address;
                in_it.dest = s_dest_address;
                in_it.len = s_length;
                in_it.fbyte = s_flash_byte;
                predict_bus_cycles(in_it);
            end
            if (result_taken) begin
                results_seen++;
                if (expected_cycles.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d unexpected: kind=%0d byte=%h addr=%h last=%b",
                                 results_seen, m_cycle_kind, m_bus_byte, m_memory_address,
                                 m_last);
                end else begin
                    want = expected_cycles.pop_front();
                    if (m_cycle_kind !== want.kind || m_bus_byte !== want.bus_byte ||
                        m_memory_address !== want.mem_addr || m_last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d: expected kind=%0d byte=%h addr=%h last=%b,",
                                      " got kind=%0d byte=%h addr=%h last=%b"},
                                     results_seen, want.kind, want.bus_byte, want.mem_addr,
                                     want.last, m_cycle_kind, m_bus_byte, m_memory_address,
                                     m_last);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin : drive
        read_item_t nxt;
        if (aresetn && (!s_valid || item_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                s_command <= nxt.cmd;
                s_start_address <= nxt.flash_start;
                s_dest_address <= nxt.dest;
                s_length <= nxt.len;
                s_flash_byte <= nxt.fbyte;
                s_valid <= 1'b1;
                items_sent++;
                // every fourth stretch of items goes back to back
                send_gap = (((items_sent / 37) % 4) == 3) ? 0 : $urandom_range(0, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : receive
        if (aresetn) begin
            if (result_taken) begin
                // hold off long enough for the input side to back up
                if (results_seen == 60 || results_seen == 1500)
                    hold_left = 300;
                recv_gap = (((results_seen / 45) % 4) == 2) ? 0 : $urandom_range(0, 4);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int r;
        logic [31:0] len;
        logic [31:0] da;

        // Directed: ignored items in idle, zero length, wrap, out-of-phase items, address extremes
        add_item(nps_pkg::CMD_READY, '1, '1, '1, 8'hFF);
        add_item(nps_pkg::CMD_DATA, '0, '0, '0, 8'hFF);
        add_item(CMD_UNUSED, '1, '1, '1, 8'hFF);
        add_item(nps_pkg::CMD_START, '1, '1, '0, 8'h00);
        add_item(nps_pkg::CMD_START, '0, '0, 32'd1, 8'h00);
        add_item(CMD_UNUSED, '0, '0, '0, 8'h00);
        add_item(nps_pkg::CMD_READY, '0, '0, '0, 8'h00);
        add_item(nps_pkg::CMD_DATA, '0, '0, '0, 8'h00);
        add_item(nps_pkg::CMD_START, '1, '1, 32'd2, 8'h00);
        add_item(nps_pkg::CMD_DATA, '0, '0, '0, 8'hAA);
        add_item(nps_pkg::CMD_READY, '1, '1, '1, 8'hFF);
        add_item(nps_pkg::CMD_READY, '0, '0, '0, 8'h00);
        add_item(nps_pkg::CMD_START, '0, '0, '1, 8'h00);
        add_item(nps_pkg::CMD_DATA, '1, '1, '1, 8'hFF);
        add_item(nps_pkg::CMD_DATA, '0, '0, '0, 8'h00);
        add_item(nps_pkg::CMD_START, 32'h0000_0800, 32'h8000_0000, 32'd1, 8'h00);
        add_item(nps_pkg::CMD_READY, '0, '0, '0, 8'h00);
        add_item(nps_pkg::CMD_DATA, '0, '0, '0, 8'h5A);
        add_item(nps_pkg::CMD_START, 32'h0000_07FF, 32'h0000_0001, 32'd3, 8'h00);
        add_item(nps_pkg::CMD_READY, '0, '0, '0, 8'h00);
        add_item(nps_pkg::CMD_DATA, '0, '0, '0, 8'h01);
        add_item(CMD_UNUSED, '0, '0, '0, 8'h00);
        add_item(nps_pkg::CMD_DATA, '0, '0, '0, 8'h80);
        add_item(nps_pkg::CMD_DATA, '0, '0, '0, 8'h7F);

        // Page-crossing reads: one with flash and memory wrap, one ending exactly on a page
        queue_read(32'hFFFF_FABC, 32'hFFFF_FFF0, nps_pkg::PAGE_STEP + 2, 1, 0);
        queue_read($urandom, $urandom, nps_pkg::PAGE_STEP, 1, 0);

        read_items_queued = 0;
        while (read_items_queued < 260) begin
            r = $urandom_range(0, 9);
            if (r < 2)
                len = '0;
            else if (r < 8)
                len = $urandom_range(1, 6);
            else if (r == 8)
                len = $urandom_range(7, 24);
            else
                len = $urandom_range(25, 60);
            da = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
            if ($urandom_range(0, 9) == 0)
                queue_read($urandom, da, len, 12, $urandom_range(1, 3));
            else
                queue_read($urandom, da, len, 12, 0);
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_cycles.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0 && expected_cycles.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/nps_pkg.sv
sv/nps_front.sv
sv/nps_queue.sv
sv/nps_back.sv
sv/nand_page_read_sequencer.sv
sv/nps_checker.sv
bench/tb.sv
